[rtl/printhead_strobe_time_unit_assert.svh]
// Assertion macros shared by the strobe time unit and its divider.
// Depends on nothing; included by the files that carry assertions.
`ifndef PRINTHEAD_STROBE_TIME_UNIT_ASSERT_SVH
`define PRINTHEAD_STROBE_TIME_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("strobe time unit: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("strobe time unit: next-cycle check failed");

`endif

[rtl/pst_pkg.sv]
// Widths, payload types, correction table and rank constants of the strobe time unit.
// Depends on nothing; used by the interfaces, the divider and the top level.
package pst_pkg;

    localparam int MV_W    = 14;
    localparam int TEMP_W  = 12;
    localparam int SUM_W   = 16;
    localparam int Q_W     = 16;
    localparam int RANK_W  = 2;

    localparam int CK_W    = 27;
    localparam int RK_W    = 18;
    localparam int TFAC_W  = 16;
    localparam int PCT_W   = 9;
    localparam int ZF_W    = 11;
    localparam int P1_W    = CK_W + TFAC_W;
    localparam int P2_W    = PCT_W + ZF_W;
    localparam int MVSQ_W  = 2 * MV_W;
    localparam int NUM_W   = P1_W + P2_W;
    localparam int DEN_W   = MVSQ_W + RK_W;

    localparam int DIV_STAGES = Q_W + 1;

    localparam logic signed [16:0] TFAC_BASE = 17'sd12200;
    localparam logic signed [16:0] TFAC_SLOPE = 17'sd11;

    localparam logic [7:0] PCT_TABLE [0:5][0:4] = '{
        '{8'd240, 8'd188, 8'd133, 8'd90, 8'd69},
        '{8'd150, 8'd121, 8'd86,  8'd53, 8'd29},
        '{8'd90,  8'd82,  8'd50,  8'd31, 8'd25},
        '{8'd63,  8'd40,  8'd31,  8'd17, 8'd17},
        '{8'd36,  8'd27,  8'd10,  8'd10, 8'd10},
        '{8'd9,   8'd5,   8'd0,   8'd0,  8'd0}
    };

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             done;
        logic             sat;
        logic [Q_W-1:0]   preset;
    } pst_div_req_t;

    typedef struct packed {
        logic [Q_W-1:0] strobe_us;
        logic           saturated;
    } pst_result_t;

    // 23 * (264 + 10 * R)^2 for each resistance rank.
    function automatic logic [CK_W-1:0] pst_k_term(input logic [RANK_W-1:0] rank);
        logic [CK_W-1:0] k;
        unique case (rank)
            2'd0:    k = 27'd107706608;
            2'd1:    k = 27'd95154588;
            2'd2:    k = 27'd83379968;
            default: k = 27'd71569008;
        endcase
        return k;
    endfunction

    // 1000 * R for each resistance rank.
    function automatic logic [RK_W-1:0] pst_r_milli(input logic [RANK_W-1:0] rank);
        logic [RK_W-1:0] r;
        unique case (rank)
            2'd0:    r = 18'd190000;
            2'd1:    r = 18'd177000;
            2'd2:    r = 18'd164000;
            default: r = 18'd150000;
        endcase
        return r;
    endfunction

endpackage

[rtl/pst_if.sv]
// Request, result and configuration channels of the strobe time unit.
// Depends on pst_pkg for the field widths.
interface pst_item_if
    import pst_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [MV_W-1:0]          supply_mv;
    logic signed [TEMP_W-1:0] head_temp_dc;
    logic [SUM_W-1:0]         row_pixel_sum;

    modport source (output valid, supply_mv, head_temp_dc, row_pixel_sum, input ready);
    modport sink (input valid, supply_mv, head_temp_dc, row_pixel_sum, output ready);
endinterface

interface pst_result_if
    import pst_pkg::*;
    ();
    logic           valid;
    logic           ready;
    logic [Q_W-1:0] strobe_us;
    logic           saturated;

    modport source (output valid, strobe_us, saturated, input ready);
    modport sink (input valid, strobe_us, saturated, output ready);
endinterface

interface pst_cfg_if
    import pst_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] head_rank;

    modport source (output valid, head_rank, input ready);
    modport sink (input valid, head_rank, output ready);
endinterface

[rtl/pst_div.sv]
// Pipelined restoring divider with saturation: an overflow check stage, then one quotient bit per stage.
// Depends on pst_pkg and printhead_strobe_time_unit_assert.svh.
`include "printhead_strobe_time_unit_assert.svh"

module pst_div
    import pst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  pst_div_req_t req,
    output logic         res_valid,
    input  logic         res_ready,
    output pst_result_t  res
);

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] en;

    logic [NUM_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [Q_W-1:0]   q_reg    [DIV_STAGES];
    logic             done_reg [DIV_STAGES];
    logic             sat_reg  [DIV_STAGES];

    logic [NUM_W-1:0] rem_next  [DIV_STAGES];
    logic [Q_W-1:0]   q_next    [DIV_STAGES];
    logic             done_next [DIV_STAGES];
    logic             sat_next  [DIV_STAGES];

    logic             ovf;

    always_comb
    begin
        en[LAST] = !valid_reg[LAST] || res_ready;
        for (int j = LAST - 1; j >= 0; j--)
        begin
            en[j] = !valid_reg[j] || en[j + 1];
        end
    end

    assign req_ready = en[0];

    // The quotient fits in sixteen bits only when the numerator is below den * 2^16.
    assign ovf = req.num >= (NUM_W'(req.den) << Q_W);

    always_comb
    begin
        logic [NUM_W-1:0] shifted;
        logic             take;
        rem_next[0]  = req.num;
        done_next[0] = req.done || ovf;
        sat_next[0]  = req.done ? req.sat : ovf;
        q_next[0]    = req.done ? req.preset : (ovf ? '1 : '0);
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            shifted      = NUM_W'(den_reg[j - 1]) << (Q_W - j);
            take         = !done_reg[j - 1] && (rem_reg[j - 1] >= shifted);
            rem_next[j]  = take ? (rem_reg[j - 1] - shifted) : rem_reg[j - 1];
            q_next[j]    = q_reg[j - 1] | (Q_W'(take) << (Q_W - j));
            done_next[j] = done_reg[j - 1];
            sat_next[j]  = sat_reg[j - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= req_valid;
            end
            for (int j = 1; j < DIV_STAGES; j++)
            begin
                if (en[j])
                begin
                    valid_reg[j] <= valid_reg[j - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            den_reg[0] <= req.den;
        end
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            if (en[j])
            begin
                den_reg[j] <= den_reg[j - 1];
            end
        end
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                done_reg[j] <= done_next[j];
                sat_reg[j]  <= sat_next[j];
            end
        end
    end

    assign res_valid     = valid_reg[LAST];
    assign res.strobe_us = q_reg[LAST];
    assign res.saturated = sat_reg[LAST];

    `PST_ASSERT_IMP(a_rem_below_den, clk, rst_n, valid_reg[LAST] && !done_reg[LAST], rem_reg[LAST] < NUM_W'(den_reg[LAST]))
    `PST_ASSERT_IMP(a_sat_is_clipped, clk, rst_n, valid_reg[LAST] && sat_reg[LAST], q_reg[LAST] == '0 || q_reg[LAST] == '1)

endmodule

[rtl/printhead_strobe_time_unit.sv]
// Top level of the print head strobe time unit: operand stages and the divider.
// Depends on pst_pkg, the channel interfaces in pst_if.sv, pst_div and the assertion header.
//
// The unit takes one request per clock cycle unless a stalled result channel has filled
// the pipeline, and returns one result per request, in order: three stages form the
// operands (band lookup, then two rows of multipliers), one stage checks for overflow and
// sixteen stages each resolve one quotient bit of the divider. Every stage holds its item
// only while the stage after it is full, so a stalled result does not stop the unit from
// taking requests until the whole pipeline is full. A new head rank applies to requests
// accepted after the write.
`include "printhead_strobe_time_unit_assert.svh"

module printhead_strobe_time_unit
    import pst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pst_cfg_if.sink       cfg,
    pst_item_if.sink      item,
    pst_result_if.source  result
);

    logic [RANK_W-1:0] rank_reg;

    logic en1;
    logic en2;
    logic en3;
    logic div_ready;

    logic signed [16:0] tfac_next;
    logic               zero_next;
    logic               hot_next;
    logic [2:0]         vb_next;
    logic [2:0]         tb_next;
    logic               vb_hit;
    logic               tb_hit;
    logic [7:0]         pct_next;

    logic              s1_valid_reg;
    logic [CK_W-1:0]   s1_ck_reg;
    logic [RK_W-1:0]   s1_rk_reg;
    logic [TFAC_W-1:0] s1_tfac_reg;
    logic [PCT_W-1:0]  s1_pct_reg;
    logic [ZF_W-1:0]   s1_zf_reg;
    logic [MV_W-1:0]   s1_mv_reg;
    logic              s1_special_reg;
    logic              s1_sat_reg;
    logic [Q_W-1:0]    s1_preset_reg;

    logic              s2_valid_reg;
    logic [P1_W-1:0]   s2_p1_reg;
    logic [P2_W-1:0]   s2_p2_reg;
    logic [MVSQ_W-1:0] s2_mvsq_reg;
    logic [RK_W-1:0]   s2_rk_reg;
    logic              s2_special_reg;
    logic              s2_sat_reg;
    logic [Q_W-1:0]    s2_preset_reg;

    logic         s3_valid_reg;
    pst_div_req_t s3_req_reg;

    pst_result_t div_res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else if (cfg.valid)
        begin
            rank_reg <= cfg.head_rank;
        end
    end

    assign en3        = !s3_valid_reg || div_ready;
    assign en2        = !s2_valid_reg || en3;
    assign en1        = !s1_valid_reg || en2;
    assign item.ready = en1;

    assign tfac_next = TFAC_BASE - (17'(item.head_temp_dc) * TFAC_SLOPE);
    assign zero_next = item.supply_mv == '0;
    assign hot_next  = tfac_next <= 17'sd0;

    always_comb
    begin
        vb_hit = 1'b1;
        priority if (item.supply_mv >= 14'd4200 && item.supply_mv <= 14'd4500)
            vb_next = 3'd0;
        else if (item.supply_mv > 14'd4500 && item.supply_mv <= 14'd5000)
            vb_next = 3'd1;
        else if (item.supply_mv > 14'd5000 && item.supply_mv <= 14'd5500)
            vb_next = 3'd2;
        else if (item.supply_mv > 14'd5500 && item.supply_mv <= 14'd6000)
            vb_next = 3'd3;
        else if (item.supply_mv > 14'd6000 && item.supply_mv <= 14'd7000)
            vb_next = 3'd4;
        else if (item.supply_mv > 14'd7000 && item.supply_mv <= 14'd8500)
            vb_next = 3'd5;
        else
        begin
            vb_next = 3'd0;
            vb_hit  = 1'b0;
        end
    end

    always_comb
    begin
        tb_hit = 1'b1;
        priority if (item.head_temp_dc >= -12'sd50 && item.head_temp_dc <= 12'sd50)
            tb_next = 3'd0;
        else if (item.head_temp_dc > 12'sd50 && item.head_temp_dc <= 12'sd200)
            tb_next = 3'd1;
        else if (item.head_temp_dc > 12'sd200 && item.head_temp_dc <= 12'sd350)
            tb_next = 3'd2;
        else if (item.head_temp_dc > 12'sd350 && item.head_temp_dc <= 12'sd500)
            tb_next = 3'd3;
        else if (item.head_temp_dc > 12'sd500 && item.head_temp_dc <= 12'sd700)
            tb_next = 3'd4;
        else
        begin
            tb_next = 3'd0;
            tb_hit  = 1'b0;
        end
    end

    assign pct_next = (vb_hit && tb_hit) ? PCT_TABLE[vb_next][tb_next] : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= item.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // A zero supply gives the full-scale result; an overheated head gives zero.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ck_reg      <= pst_k_term(rank_reg);
            s1_rk_reg      <= pst_r_milli(rank_reg);
            s1_tfac_reg    <= tfac_next[TFAC_W-1:0];
            s1_pct_reg     <= PCT_W'(pct_next) + PCT_W'(100);
            s1_zf_reg      <= ZF_W'(item.row_pixel_sum[SUM_W-1:6]) + ZF_W'(100);
            s1_mv_reg      <= item.supply_mv;
            s1_special_reg <= zero_next || hot_next;
            s1_sat_reg     <= zero_next || (tfac_next < 17'sd0);
            s1_preset_reg  <= zero_next ? '1 : '0;
        end
        if (en2)
        begin
            s2_p1_reg      <= P1_W'(s1_ck_reg) * P1_W'(s1_tfac_reg);
            s2_p2_reg      <= P2_W'(s1_pct_reg) * P2_W'(s1_zf_reg);
            s2_mvsq_reg    <= MVSQ_W'(s1_mv_reg) * MVSQ_W'(s1_mv_reg);
            s2_rk_reg      <= s1_rk_reg;
            s2_special_reg <= s1_special_reg;
            s2_sat_reg     <= s1_sat_reg;
            s2_preset_reg  <= s1_preset_reg;
        end
        if (en3)
        begin
            s3_req_reg.num    <= NUM_W'(s2_p1_reg) * NUM_W'(s2_p2_reg);
            s3_req_reg.den    <= DEN_W'(s2_mvsq_reg) * DEN_W'(s2_rk_reg);
            s3_req_reg.done   <= s2_special_reg;
            s3_req_reg.sat    <= s2_sat_reg;
            s3_req_reg.preset <= s2_preset_reg;
        end
    end

    pst_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s3_valid_reg),
        .req_ready (div_ready),
        .req       (s3_req_reg),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (div_res)
    );

    assign result.strobe_us = div_res.strobe_us;
    assign result.saturated = div_res.saturated;

    `PST_ASSERT_NEXT(a_zero_mv_special, clk, rst_n, item.valid && item.ready && item.supply_mv == '0, s1_valid_reg && s1_special_reg && s1_sat_reg)
    `PST_ASSERT_IMP(a_den_nonzero, clk, rst_n, s3_valid_reg && !s3_req_reg.done, s3_req_reg.den != '0)

endmodule
